>>> sv/sdl_pkg.sv
// Shared constants, types and helper functions of the stereo chorus delay line.
package sdl_pkg;

    localparam int MAX_LINE = 4096;
    localparam int ADDR_W   = $clog2(MAX_LINE);
    localparam int LEN_W    = ADDR_W + 1;
    localparam int SMP_W    = 16;
    localparam int DLY_W    = ADDR_W + 8;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    localparam logic [16:0] GAIN_ONE = 17'd32768;

    localparam logic [IDX_W-1:0] CFG_LINE_LENGTH   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CROSS_MIX     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
    localparam logic [IDX_W-1:0] CFG_INVERT_OUTPUT = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PAN           = 3'd4;
    localparam logic [IDX_W-1:0] CFG_VOLUME        = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]        line_length;
        logic [15:0]             cross_mix;
        logic signed [15:0]      feedback_gain;
        logic                    invert_output;
        logic [15:0]             pan;
        logic [15:0]             volume;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic clamp;
        logic addr;
        logic rd_lo;
        logic rd_hi;
        logic interp;
        logic wet;
        logic fbk;
        logic write;
        logic outp;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } stat_t;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [47:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] cap_one(input logic [15:0] g);
        logic [15:0] r;
        r = (g > 16'd32768) ? 16'd32768 : g;
        return r;
    endfunction

endpackage

>>> sv/sdl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/sdl_ctrl.sv
// Controller state machine that sequences the clearing pass and each sample pair.
module sdl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  sdl_pkg::stat_t stat,
    output sdl_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CLAMP  = 4'd2;
    localparam logic [3:0] ST_ADDR   = 4'd3;
    localparam logic [3:0] ST_RD_LO  = 4'd4;
    localparam logic [3:0] ST_RD_HI  = 4'd5;
    localparam logic [3:0] ST_INTERP = 4'd6;
    localparam logic [3:0] ST_WET    = 4'd7;
    localparam logic [3:0] ST_FBK    = 4'd8;
    localparam logic [3:0] ST_WRITE  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_RD_LO;
            end
            ST_RD_LO: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = ST_WET;
            end
            ST_WET: begin
                cmd.wet    = 1'b1;
                state_next = ST_FBK;
            end
            ST_FBK: begin
                cmd.fbk    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.outp   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.outp) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

>>> sv/sdl_datapath.sv
// Datapath: cross mix, write pointer, interpolated line reads, feedback write and output gain.
module sdl_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  sdl_pkg::cmd_t  cmd,
    input  sdl_pkg::cfg_t  cfg,
    input  logic [71:0]    in_data,
    output logic [31:0]    out_data,
    output sdl_pkg::stat_t stat
);

    logic [sdl_pkg::LEN_W-1:0]  len_eff;
    logic [sdl_pkg::LEN_W-1:0]  len_m1;
    logic [sdl_pkg::LEN_W-1:0]  wp_inc;
    logic [sdl_pkg::ADDR_W-1:0] wp_reg, wp_next;
    logic [sdl_pkg::ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [15:0]                cmix_cap, pan_cap, vol_cap;
    logic [15:0]                pan_rest;
    logic [31:0]                gain_mul [2];

    logic signed [sdl_pkg::SMP_W-1:0] in_smp [2];
    logic [sdl_pkg::DLY_W-1:0]        in_dly [2];
    logic signed [sdl_pkg::SMP_W-1:0] smp_reg [2];
    logic [sdl_pkg::DLY_W-1:0]        dly_reg [2];
    logic signed [sdl_pkg::SMP_W-1:0] res_data [2];

    assign in_smp[0] = signed'(in_data[15:0]);
    assign in_smp[1] = signed'(in_data[31:16]);
    assign in_dly[0] = in_data[51:32];
    assign in_dly[1] = in_data[71:52];

    always_comb begin
        if (cfg.line_length < 13'd2) begin
            len_eff = 13'd2;
        end else if (cfg.line_length > 13'(sdl_pkg::MAX_LINE)) begin
            len_eff = 13'(sdl_pkg::MAX_LINE);
        end else begin
            len_eff = cfg.line_length;
        end
    end

    assign len_m1  = len_eff - 13'd1;
    assign wp_inc  = {1'b0, wp_reg} + 13'd1;
    assign wp_next = cmd.load ? ((wp_inc >= len_eff) ? '0 : wp_inc[sdl_pkg::ADDR_W-1:0])
                              : wp_reg;
    assign clr_cnt_next = cmd.clear ? clr_cnt_reg + 12'd1 : clr_cnt_reg;
    assign stat.clr_last = (clr_cnt_reg == 12'(sdl_pkg::MAX_LINE - 1));

    assign cmix_cap = sdl_pkg::cap_one(cfg.cross_mix);
    assign pan_cap  = sdl_pkg::cap_one(cfg.pan);
    assign vol_cap  = sdl_pkg::cap_one(cfg.volume);
    assign pan_rest = 16'(sdl_pkg::GAIN_ONE - {1'b0, pan_cap});

    assign gain_mul[0] = 32'(pan_cap) * 32'(vol_cap);
    assign gain_mul[1] = 32'(pan_rest) * 32'(vol_cap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            clr_cnt_reg <= '0;
        end else begin
            wp_reg      <= wp_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            smp_reg[0] <= in_smp[0];
            smp_reg[1] <= in_smp[1];
            dly_reg[0] <= in_dly[0];
            dly_reg[1] <= in_dly[1];
        end
    end

    for (genvar ch = 0; ch < 2; ch++) begin : gen_ch
        logic signed [16:0]                xdiff;
        logic signed [33:0]                xmul, xsum;
        logic signed [33:0]                xprod_reg;
        logic [sdl_pkg::DLY_W-1:0]         maxd, dcl, dcl_reg;
        logic [30:0]                       gain_reg;
        logic [sdl_pkg::ADDR_W-1:0]        di;
        logic [7:0]                        df;
        logic [13:0]                       pos, pos_wrap;
        logic [sdl_pkg::ADDR_W-1:0]        hi_c, lo_c, hi_reg, lo_reg;
        logic [7:0]                        f_reg;
        logic signed [33:0]                xr;
        logic signed [sdl_pkg::SMP_W-1:0]  xin_reg;
        logic signed [sdl_pkg::SMP_W-1:0]  hi_dat, lo_dat_reg;
        logic [sdl_pkg::SMP_W-1:0]         rdata;
        logic signed [16:0]                idiff;
        logic signed [25:0]                imul, acc, acc_reg, accr;
        logic signed [sdl_pkg::SMP_W-1:0]  wet_reg, inv_c, inv_reg;
        logic signed [16:0]                wet_neg;
        logic signed [31:0]                fprod_reg, fr;
        logic signed [32:0]                wsum;
        logic signed [sdl_pkg::SMP_W-1:0]  wdata_c;
        logic signed [47:0]                gprod_reg, gr;
        logic signed [sdl_pkg::SMP_W-1:0]  res_reg;
        logic                              ram_we;
        logic [sdl_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
        logic [sdl_pkg::SMP_W-1:0]         ram_wdata;

        assign xdiff = 17'(smp_reg[1-ch]) - 17'(smp_reg[ch]);
        assign xmul  = xdiff * signed'({1'b0, cmix_cap});
        assign xsum  = xmul + (34'(smp_reg[ch]) <<< 15);

        assign maxd = {len_m1[sdl_pkg::ADDR_W-1:0], 8'h00};
        assign dcl  = (dly_reg[ch] > maxd) ? maxd : dly_reg[ch];

        assign di       = dcl_reg[sdl_pkg::DLY_W-1:8];
        assign df       = dcl_reg[7:0];
        assign pos      = {2'b00, wp_reg} - {2'b00, di} - {13'd0, |df};
        assign pos_wrap = pos + 14'(len_eff);
        assign hi_c     = pos[13] ? pos_wrap[sdl_pkg::ADDR_W-1:0] : pos[sdl_pkg::ADDR_W-1:0];
        assign lo_c     = (hi_c == '0) ? len_m1[sdl_pkg::ADDR_W-1:0] : hi_c - 12'd1;

        assign xr = (xprod_reg + 34'sd16384) >>> 15;

        assign hi_dat = signed'(rdata);
        assign idiff  = 17'(hi_dat) - 17'(lo_dat_reg);
        assign imul   = idiff * signed'({1'b0, f_reg});
        assign acc    = imul + (26'(lo_dat_reg) <<< 8);
        assign accr   = (acc_reg + 26'sd128) >>> 8;

        assign wet_neg = -17'(wet_reg);
        assign inv_c   = cfg.invert_output ? sdl_pkg::sat16(48'(wet_neg)) : wet_reg;

        assign fr      = (fprod_reg + 32'sd16384) >>> 15;
        assign wsum    = 33'(xin_reg) + 33'(fr);
        assign wdata_c = sdl_pkg::sat16(48'(wsum));

        assign gr = (gprod_reg + 48'sd536870912) >>> 30;

        always_ff @(posedge aclk) begin
            if (cmd.clamp) begin
                xprod_reg <= xsum;
                dcl_reg   <= dcl;
                gain_reg  <= gain_mul[ch][30:0];
            end
            if (cmd.addr) begin
                hi_reg  <= hi_c;
                lo_reg  <= lo_c;
                f_reg   <= 8'd0 - df;
                xin_reg <= sdl_pkg::sat16(48'(xr));
            end
            if (cmd.rd_hi) begin
                lo_dat_reg <= signed'(rdata);
            end
            if (cmd.interp) begin
                acc_reg <= acc;
            end
            if (cmd.wet) begin
                wet_reg <= sdl_pkg::sat16(48'(accr));
            end
            if (cmd.fbk) begin
                fprod_reg <= wet_reg * cfg.feedback_gain;
                inv_reg   <= inv_c;
            end
            if (cmd.write) begin
                gprod_reg <= inv_reg * signed'({1'b0, gain_reg});
            end
            if (cmd.outp) begin
                res_reg <= sdl_pkg::sat16(gr);
            end
        end

        assign ram_we    = cmd.write | cmd.clear;
        assign ram_waddr = cmd.clear ? clr_cnt_reg : wp_reg;
        assign ram_wdata = cmd.clear ? '0 : wdata_c;
        assign ram_raddr = cmd.rd_lo ? lo_reg : hi_reg;

        sdl_ram #(
            .WIDTH(sdl_pkg::SMP_W),
            .DEPTH(sdl_pkg::MAX_LINE)
        ) u_line (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .raddr (ram_raddr),
            .rdata (rdata)
        );

        assign res_data[ch] = res_reg;
    end

    assign out_data = {res_data[1], res_data[0]};

endmodule

>>> sv/stereo_chorus_delay_line.sv
// Top level of the stereo chorus delay line: configuration registers and block wiring.
//
// Each stereo pair's result is held in an output register that drives m_tdata. A new pair
// is taken only once the previous one has finished: the controller walks one pair through
// cross mix, address calculation, two reads of each line's single read port, interpolation,
// feedback write and output gain in turn. After reset both lines are cleared, all 4096
// entries, one entry a cycle, while s_tready stays low; configuration writes are taken
// throughout. A finished result waits in the output register while the next pair is
// processed, and that pair holds in its output step until that result is transferred.
module stereo_chorus_delay_line (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [71:0]               s_tdata,   // left_in, right_in, left_delay, right_delay
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // left_out, right_out
    input  logic                      cfg_we,
    input  logic [sdl_pkg::IDX_W-1:0] cfg_index,
    input  logic [sdl_pkg::CFG_W-1:0] cfg_wdata
);

    sdl_pkg::cfg_t  cfg_reg;
    sdl_pkg::cmd_t  cmd;
    sdl_pkg::stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_length   <= 13'(sdl_pkg::MAX_LINE);
            cfg_reg.cross_mix     <= 16'd0;
            cfg_reg.feedback_gain <= 16'sd0;
            cfg_reg.invert_output <= 1'b0;
            cfg_reg.pan           <= 16'd16384;
            cfg_reg.volume        <= 16'd32768;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sdl_pkg::CFG_LINE_LENGTH:   cfg_reg.line_length   <= cfg_wdata[12:0];
                sdl_pkg::CFG_CROSS_MIX:     cfg_reg.cross_mix     <= cfg_wdata;
                sdl_pkg::CFG_FEEDBACK_GAIN: cfg_reg.feedback_gain <= signed'(cfg_wdata);
                sdl_pkg::CFG_INVERT_OUTPUT: cfg_reg.invert_output <= cfg_wdata[0];
                sdl_pkg::CFG_PAN:           cfg_reg.pan           <= cfg_wdata;
                sdl_pkg::CFG_VOLUME:        cfg_reg.volume        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sdl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sdl_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .stat     (stat)
    );

endmodule
